FILE: sv/double_ended_priority_queue_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the double-ended priority queue
// Concurrent check wrappers; compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_PRIORITY_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_PRIORITY_QUEUE_ASSERT_SVH

`ifndef ASSERT_OFF

// checked only while out of reset
`define DEP_ASSERT_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// checked at every edge, reset included
`define DEP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define DEP_ASSERT_RST(lbl, clk, rstn, prop, msg)

`define DEP_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

FILE: sv/dep_pkg.sv
// ----------------------------------------------------------------------------
// dep_pkg
// Shared types and constants of the double-ended priority queue.
// ----------------------------------------------------------------------------
package dep_pkg;

    localparam int DATA_W  = 32;
    localparam int CMD_W   = 2;
    localparam int COUNT_W = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT  = 2'd0,
        CMD_DEL_MAX = 2'd1,
        CMD_DEL_MIN = 2'd2
    } cmd_e_t;

    // per-chain operation broadcast to every cell
    typedef struct packed {
        logic insert;
        logic pop;
        logic trim;
    } op_t;

    typedef struct packed {
        logic head_valid;
        logic full;
    } chain_status_t;

endpackage

FILE: sv/dep_cell.sv
// ----------------------------------------------------------------------------
// dep_cell
// One slot of a sorted chain: holds a value and a valid bit, compares the
// broadcast value and trades data with its neighbors.
// ----------------------------------------------------------------------------
module dep_cell #(
    parameter bit DESCEND = 1'b0
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  dep_pkg::op_t                        op,
    input  logic signed [dep_pkg::DATA_W-1:0]   value,
    input  logic signed [dep_pkg::DATA_W-1:0]   prev_data,
    input  logic                                prev_valid,
    input  logic                                prev_take,
    input  logic signed [dep_pkg::DATA_W-1:0]   next_data,
    input  logic                                next_valid,
    output logic                                take,
    output logic signed [dep_pkg::DATA_W-1:0]   data,
    output logic                                valid,
    output logic signed [dep_pkg::DATA_W-1:0]   data_next,
    output logic                                valid_next
);

    logic signed [dep_pkg::DATA_W-1:0] data_reg;
    logic                              valid_reg;
    logic                              goes_before;

    // new value lands behind entries equal to it
    assign goes_before = DESCEND ? (data_reg < value) : (value < data_reg);
    assign take        = !valid_reg || goes_before;

    always_comb
    begin
        data_next  = data_reg;
        valid_next = valid_reg;
        priority if (op.insert)
        begin
            if (prev_take)
            begin
                data_next = prev_data;
            end
            else if (take)
            begin
                data_next = value;
            end
            valid_next = valid_reg || prev_valid;
        end
        else if (op.pop)
        begin
            data_next  = next_data;
            valid_next = next_valid;
        end
        else if (op.trim)
        begin
            valid_next = valid_reg && next_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op.insert || op.pop)
        begin
            data_reg <= data_next;
        end
    end

    assign data  = data_reg;
    assign valid = valid_reg;

endmodule

FILE: sv/dep_chain.sv
// ----------------------------------------------------------------------------
// dep_chain
// Row of cells kept in sorted order, head at cell 0; insert in place,
// pop at the head, trim at the tail.
// ----------------------------------------------------------------------------
module dep_chain #(
    parameter int  CAPACITY = 64,
    parameter bit  DESCEND  = 1'b0
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  dep_pkg::op_t                        op,
    input  logic signed [dep_pkg::DATA_W-1:0]   value,
    output dep_pkg::chain_status_t              status,
    output logic signed [dep_pkg::DATA_W-1:0]   head_data_next,
    output logic                                head_valid_next
);

    logic signed [dep_pkg::DATA_W-1:0] cell_data      [CAPACITY];
    logic signed [dep_pkg::DATA_W-1:0] cell_data_next [CAPACITY];
    logic                              cell_valid     [CAPACITY];
    logic                              cell_valid_next[CAPACITY];
    logic                              cell_take      [CAPACITY];

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [dep_pkg::DATA_W-1:0] prev_data;
        logic                              prev_valid;
        logic                              prev_take;
        logic signed [dep_pkg::DATA_W-1:0] next_data;
        logic                              next_valid;

        if (i == 0)
        begin : g_first
            assign prev_data  = '0;
            assign prev_valid = 1'b1;
            assign prev_take  = 1'b0;
        end
        else
        begin : g_mid
            assign prev_data  = cell_data[i-1];
            assign prev_valid = cell_valid[i-1];
            assign prev_take  = cell_take[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign next_data  = '0;
            assign next_valid = 1'b0;
        end
        else
        begin : g_inner
            assign next_data  = cell_data[i+1];
            assign next_valid = cell_valid[i+1];
        end

        dep_cell #(
            .DESCEND (DESCEND)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .op         (op),
            .value      (value),
            .prev_data  (prev_data),
            .prev_valid (prev_valid),
            .prev_take  (prev_take),
            .next_data  (next_data),
            .next_valid (next_valid),
            .take       (cell_take[i]),
            .data       (cell_data[i]),
            .valid      (cell_valid[i]),
            .data_next  (cell_data_next[i]),
            .valid_next (cell_valid_next[i])
        );
    end

    assign status.head_valid = cell_valid[0];
    assign status.full       = cell_valid[CAPACITY-1];
    assign head_data_next    = cell_data_next[0];
    assign head_valid_next   = cell_valid_next[0];

endmodule

FILE: sv/double_ended_priority_queue.sv
// ----------------------------------------------------------------------------
// double_ended_priority_queue
// Bounded multiset of signed 32-bit values with insert, delete-max and
// delete-min, reporting max, min, count and flags after every command.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: cmd_valid / cmd_stall with cmd and value. A transaction
//   is taken when cmd_valid is high and cmd_stall is low.
//   Result channel: res_valid / res_stall with max_value, min_value, count,
//   is_empty and dropped; one result transaction per command.
//   Storage is two rows of CAPACITY cells, one sorted ascending (min at its
//   head) and one descending (max at its head); every cell compares the
//   broadcast value and shifts with its neighbor in the same cycle.
//   Result: registered, and shows in the cycle after the command is taken.
//   Throughput: one command per cycle while no result stall holds the queue.
//   Stall: while a result waits under res_stall, cmd_stall is high and the
//   queue holds its state and result.
//   Reset: all cells read empty and count is zero; no clearing pass.
//   Delete on empty is ignored; insert when full leaves the state as is and
//   reports dropped. Unused command codes only report the current state.
// ----------------------------------------------------------------------------
`include "double_ended_priority_queue_assert.svh"

module double_ended_priority_queue #(
    parameter int CAPACITY = 64
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cmd_valid,
    output logic                                  cmd_stall,
    input  logic [dep_pkg::CMD_W-1:0]             cmd,
    input  logic signed [dep_pkg::DATA_W-1:0]     value,
    output logic                                  res_valid,
    input  logic                                  res_stall,
    output logic signed [dep_pkg::DATA_W-1:0]     max_value,
    output logic signed [dep_pkg::DATA_W-1:0]     min_value,
    output logic [dep_pkg::COUNT_W-1:0]           count,
    output logic                                  is_empty,
    output logic                                  dropped
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    dep_pkg::cmd_e_t                   cmd_code;
    dep_pkg::op_t                      op_asc;
    dep_pkg::op_t                      op_desc;
    dep_pkg::chain_status_t            asc_status;
    dep_pkg::chain_status_t            desc_status;
    logic signed [dep_pkg::DATA_W-1:0] asc_head_next;
    logic signed [dep_pkg::DATA_W-1:0] desc_head_next;
    logic                              asc_head_valid_next;
    logic                              desc_head_valid_next;

    logic                              accept;
    logic                              drop;
    logic [CNT_W-1:0]                  cnt_reg;
    logic [CNT_W-1:0]                  cnt_next;
    logic [dep_pkg::COUNT_W-1:0]       cnt_low;

    logic                              res_valid_reg;
    logic signed [dep_pkg::DATA_W-1:0] max_reg;
    logic signed [dep_pkg::DATA_W-1:0] min_reg;
    logic [dep_pkg::COUNT_W-1:0]       count_reg;
    logic                              empty_reg;
    logic                              dropped_reg;

    assign cmd_stall = res_valid_reg && res_stall;
    assign accept    = cmd_valid && !cmd_stall;
    assign cmd_code  = dep_pkg::cmd_e_t'(cmd);

    always_comb
    begin
        op_asc   = '0;
        op_desc  = '0;
        drop     = 1'b0;
        cnt_next = cnt_reg;
        if (accept)
        begin
            unique case (cmd_code)
                dep_pkg::CMD_INSERT:
                begin
                    if (asc_status.full)
                    begin
                        drop = 1'b1;
                    end
                    else
                    begin
                        op_asc.insert  = 1'b1;
                        op_desc.insert = 1'b1;
                        cnt_next       = cnt_reg + CNT_W'(1);
                    end
                end
                dep_pkg::CMD_DEL_MAX:
                begin
                    if (asc_status.head_valid)
                    begin
                        op_asc.trim = 1'b1;
                        op_desc.pop = 1'b1;
                        cnt_next    = cnt_reg - CNT_W'(1);
                    end
                end
                dep_pkg::CMD_DEL_MIN:
                begin
                    if (asc_status.head_valid)
                    begin
                        op_asc.pop   = 1'b1;
                        op_desc.trim = 1'b1;
                        cnt_next     = cnt_reg - CNT_W'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    if (CNT_W >= dep_pkg::COUNT_W)
    begin : g_cnt_trunc
        assign cnt_low = cnt_next[dep_pkg::COUNT_W-1:0];
    end
    else
    begin : g_cnt_ext
        assign cnt_low = {{(dep_pkg::COUNT_W - CNT_W){1'b0}}, cnt_next};
    end

    dep_chain #(
        .CAPACITY (CAPACITY),
        .DESCEND  (1'b0)
    ) u_asc (
        .clk             (clk),
        .rst_n           (rst_n),
        .op              (op_asc),
        .value           (value),
        .status          (asc_status),
        .head_data_next  (asc_head_next),
        .head_valid_next (asc_head_valid_next)
    );

    dep_chain #(
        .CAPACITY (CAPACITY),
        .DESCEND  (1'b1)
    ) u_desc (
        .clk             (clk),
        .rst_n           (rst_n),
        .op              (op_desc),
        .value           (value),
        .status          (desc_status),
        .head_data_next  (desc_head_next),
        .head_valid_next (desc_head_valid_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (accept)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            max_reg     <= desc_head_valid_next ? desc_head_next : '0;
            min_reg     <= asc_head_valid_next ? asc_head_next : '0;
            count_reg   <= cnt_low;
            empty_reg   <= !asc_head_valid_next;
            dropped_reg <= drop;
        end
    end

    assign res_valid = res_valid_reg;
    assign max_value = max_reg;
    assign min_value = min_reg;
    assign count     = count_reg;
    assign is_empty  = empty_reg;
    assign dropped   = dropped_reg;

    `DEP_ASSERT_ALWAYS(a_chains_agree, clk, (asc_status.full == desc_status.full) && (asc_status.head_valid == desc_status.head_valid), "sorted rows disagree on fill")
    `DEP_ASSERT_RST(a_count_tracks_cells, clk, rst_n, (cnt_reg == '0) == !asc_status.head_valid, "count and cell valid bits disagree")
    `DEP_ASSERT_RST(a_drop_only_full, clk, rst_n, (res_valid && dropped) |-> asc_status.full, "dropped reported while queue not full")
    `DEP_ASSERT_RST(a_max_ge_min, clk, rst_n, (res_valid && !is_empty) |-> (max_value >= min_value), "reported max below min")

endmodule

FILE: test/double_ended_priority_queue_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_priority_queue_test
// Self-checking bench for the double-ended priority queue. A directed table
// covers empty deletes, extreme values, duplicates and the unused command code.
// A phased random stream follows: fill, drain and mixed phases that reach the
// full queue and dropped inserts. Both channels idle at random, and the
// result side holds off once for a long stretch. Every result transaction is
// compared field by field against an in-bench sorted-queue model.
// ----------------------------------------------------------------------------
module double_ended_priority_queue_test;

    localparam int CMD_W   = dep_pkg::CMD_W;
    localparam int DATA_W  = dep_pkg::DATA_W;
    localparam int COUNT_W = dep_pkg::COUNT_W;

    localparam int CAPACITY     = 64;
    localparam int RANDOM_ITEMS = 700;
    localparam int DIR_N        = 25;
    localparam int IDLE_PCT     = 23;
    localparam int HOLD_CYCLES  = 200;
    localparam int HOLD_AT      = 520;
    localparam int WATCHDOG     = 2000;
    localparam int DRAIN_CYCLES = 8;

    localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [DATA_W-1:0] max_v;
        logic signed [DATA_W-1:0] min_v;
        logic [COUNT_W-1:0]       cnt;
        logic                     empty;
        logic                     drop;
    } queue_status_t;

    typedef struct packed {
        logic [CMD_W-1:0]         op;
        logic signed [DATA_W-1:0] val;
        logic                     typed;
        queue_status_t            status;
    } dir_row_t;

    localparam queue_status_t EMPTY_STATUS = '{32'sd0, 32'sd0, 7'd0, 1'b1, 1'b0};
    localparam queue_status_t UNTYPED      = '0;

    localparam dir_row_t DIRECTED [DIR_N] = '{
        '{dep_pkg::CMD_DEL_MAX, 32'sd0,         1'b1, EMPTY_STATUS},
        '{dep_pkg::CMD_DEL_MIN, 32'sd0,         1'b1, EMPTY_STATUS},
        '{CMD_NOP,              32'sh1234_5678, 1'b1, EMPTY_STATUS},
        '{dep_pkg::CMD_INSERT,  VAL_MAX,        1'b1, '{VAL_MAX, VAL_MAX, 7'd1, 1'b0, 1'b0}},
        '{dep_pkg::CMD_INSERT,  VAL_MIN,        1'b1, '{VAL_MAX, VAL_MIN, 7'd2, 1'b0, 1'b0}},
        '{dep_pkg::CMD_INSERT,  32'sd0,         1'b1, '{VAL_MAX, VAL_MIN, 7'd3, 1'b0, 1'b0}},
        '{dep_pkg::CMD_INSERT,  -32'sd1,        1'b0, UNTYPED},
        '{dep_pkg::CMD_INSERT,  32'sd1,         1'b0, UNTYPED},
        '{dep_pkg::CMD_INSERT,  32'sd0,         1'b0, UNTYPED},
        '{dep_pkg::CMD_INSERT,  VAL_MAX,        1'b0, UNTYPED},
        '{dep_pkg::CMD_INSERT,  VAL_MIN,        1'b0, UNTYPED},
        '{CMD_NOP,              32'shA5A5_A5A5, 1'b0, UNTYPED},
        '{dep_pkg::CMD_DEL_MAX, 32'shFFFF_FFFF, 1'b0, UNTYPED},
        '{dep_pkg::CMD_DEL_MAX, 32'sd0,         1'b0, UNTYPED},
        '{dep_pkg::CMD_DEL_MIN, 32'sh5A5A_5A5A, 1'b0, UNTYPED},
        '{dep_pkg::CMD_DEL_MIN, 32'sd0,         1'b0, UNTYPED},
        '{dep_pkg::CMD_INSERT,  32'sh5555_5555, 1'b0, UNTYPED},
        '{dep_pkg::CMD_INSERT,  32'shAAAA_AAAA, 1'b0, UNTYPED},
        '{dep_pkg::CMD_DEL_MIN, 32'sd0,         1'b0, UNTYPED},
        '{dep_pkg::CMD_DEL_MAX, 32'sd0,         1'b0, UNTYPED},
        '{dep_pkg::CMD_DEL_MIN, 32'sd0,         1'b0, UNTYPED},
        '{dep_pkg::CMD_DEL_MAX, 32'sd0,         1'b0, UNTYPED},
        '{dep_pkg::CMD_DEL_MIN, 32'sd0,         1'b0, UNTYPED},
        '{dep_pkg::CMD_DEL_MAX, 32'sd0,         1'b1, EMPTY_STATUS},
        '{dep_pkg::CMD_DEL_MIN, 32'sd0,         1'b1, EMPTY_STATUS}
    };

    logic                     clk;
    logic                     rst_n;
    logic                     cmd_valid;
    logic                     cmd_stall;
    logic [CMD_W-1:0]         cmd;
    logic signed [DATA_W-1:0] value;
    logic                     res_valid;
    logic                     res_stall;
    logic signed [DATA_W-1:0] max_value;
    logic signed [DATA_W-1:0] min_value;
    logic [COUNT_W-1:0]       count;
    logic                     is_empty;
    logic                     dropped;

    logic                     row_typed;
    queue_status_t            row_status;
    logic                     quiet;

    logic signed [DATA_W-1:0] stored_vals [$];
    queue_status_t            pending_status [$];

    int error_count;
    int accepted_cmds;
    int checked_results;
    int drop_count;
    int full_count;
    int empty_delete_count;
    int stall_cycles;

    double_ended_priority_queue #(
        .CAPACITY (CAPACITY)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .value     (value),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .max_value (max_value),
        .min_value (min_value),
        .count     (count),
        .is_empty  (is_empty),
        .dropped   (dropped)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // sorted-multiset model; equal values go after existing ones
    function automatic queue_status_t apply_command(input logic [CMD_W-1:0] op,
                                                    input logic signed [DATA_W-1:0] val);
        queue_status_t st;
        int            pos;
        st = '0;
        if (op == dep_pkg::CMD_INSERT)
        begin
            if (stored_vals.size() >= CAPACITY)
            begin
                st.drop = 1'b1;
            end
            else
            begin
                pos = stored_vals.size();
                for (int k = 0; k < stored_vals.size(); k++)
                begin
                    if (stored_vals[k] > val)
                    begin
                        pos = k;
                        break;
                    end
                end
                stored_vals.insert(pos, val);
            end
        end
        else if (op == dep_pkg::CMD_DEL_MAX || op == dep_pkg::CMD_DEL_MIN)
        begin
            if (stored_vals.size() == 0)
            begin
                empty_delete_count++;
            end
            else if (op == dep_pkg::CMD_DEL_MAX)
            begin
                void'(stored_vals.pop_back());
            end
            else
            begin
                void'(stored_vals.pop_front());
            end
        end
        st.cnt   = COUNT_W'(stored_vals.size());
        st.empty = (stored_vals.size() == 0);
        if (stored_vals.size() != 0)
        begin
            st.max_v = stored_vals[$];
            st.min_v = stored_vals[0];
        end
        return st;
    endfunction

    function automatic void check_field(input string name,
                                        input logic [DATA_W-1:0] want,
                                        input logic [DATA_W-1:0] got);
        if (want !== got)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : monitor
        queue_status_t st;
        queue_status_t want;
        if (rst_n)
        begin
            if (cmd_valid && !cmd_stall)
            begin
                st = apply_command(cmd, value);
                if (row_typed)
                begin
                    st = row_status;
                end
                if (st.drop)
                begin
                    drop_count++;
                end
                if (st.cnt == CAPACITY)
                begin
                    full_count++;
                end
                pending_status.insert(pending_status.size(), st);
                accepted_cmds++;
            end
            if (res_valid && !res_stall)
            begin
                if (pending_status.size() == 0)
                begin
                    error_count++;
                    $display("%0t: result transaction with nothing expected", $time);
                end
                else
                begin
                    want = pending_status.pop_front();
                    check_field("max_value", want.max_v, max_value);
                    check_field("min_value", want.min_v, min_value);
                    check_field("count", DATA_W'(want.cnt), DATA_W'(count));
                    check_field("is_empty", DATA_W'(want.empty), DATA_W'(is_empty));
                    check_field("dropped", DATA_W'(want.drop), DATA_W'(dropped));
                    checked_results++;
                end
            end
            if (cmd_valid && cmd_stall)
            begin
                stall_cycles++;
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        int quiet_cycles;
        if (!rst_n || (cmd_valid && !cmd_stall) || (res_valid && !res_stall))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG)
            begin
                $display("%0t: no transaction for %0d cycles", $time, WATCHDOG);
                $display("double_ended_priority_queue verification failed");
                $finish;
            end
        end
    end

    initial
    begin : receiver
        int  hold_left;
        bit  held;
        hold_left = 0;
        held      = 1'b0;
        res_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held && accepted_cmds >= HOLD_AT)
            begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_stall <= 1'b1;
            end
            else if (quiet)
            begin
                res_stall <= 1'b0;
            end
            else
            begin
                res_stall <= ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    task automatic send_cmd(input logic [CMD_W-1:0] op,
                            input logic signed [DATA_W-1:0] val,
                            input logic typed,
                            input queue_status_t status);
        while (!quiet && $urandom_range(99) < IDLE_PCT)
        begin
            cmd_valid <= 1'b0;
            cmd       <= CMD_W'($urandom);
            value     <= $urandom;
            @(negedge clk);
        end
        cmd_valid  <= 1'b1;
        cmd        <= op;
        value      <= val;
        row_typed  <= typed;
        row_status <= status;
        @(posedge clk);
        while (cmd_stall)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    function automatic logic signed [DATA_W-1:0] random_value();
        int pick;
        pick = $urandom_range(99);
        if (pick < 50)
        begin
            return $urandom;
        end
        else if (pick < 75)
        begin
            return $signed($urandom_range(15)) - 8;
        end
        else if (pick < 85)
        begin
            case ($urandom_range(3))
                0:       return VAL_MAX;
                1:       return VAL_MIN;
                2:       return 32'sd0;
                default: return -32'sd1;
            endcase
        end
        return $urandom & $urandom;
    endfunction

    // per phase: 0 fill, 1 mixed, 2 drain
    function automatic logic [CMD_W-1:0] random_cmd(input int phase);
        int pick;
        int insert_pct;
        pick = $urandom_range(99);
        insert_pct = (phase == 0) ? 85 : (phase == 2) ? 15 : 50;
        if (pick < 4)
        begin
            return CMD_NOP;
        end
        else if ($urandom_range(99) < insert_pct)
        begin
            return dep_pkg::CMD_INSERT;
        end
        return ($urandom_range(1) != 0) ? dep_pkg::CMD_DEL_MAX : dep_pkg::CMD_DEL_MIN;
    endfunction

    initial
    begin : driver
        int phase_of_block [7];
        phase_of_block = '{0, 1, 2, 0, 0, 2, 1};
        error_count        = 0;
        accepted_cmds      = 0;
        checked_results    = 0;
        drop_count         = 0;
        full_count         = 0;
        empty_delete_count = 0;
        stall_cycles       = 0;
        quiet      = 1'b0;
        rst_n      = 1'b0;
        cmd_valid  = 1'b0;
        cmd        = dep_pkg::CMD_INSERT;
        value      = '0;
        row_typed  = 1'b0;
        row_status = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int r = 0; r < DIR_N; r++)
        begin
            send_cmd(DIRECTED[r].op, DIRECTED[r].val, DIRECTED[r].typed, DIRECTED[r].status);
        end

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            quiet <= (i >= 300 && i < 420);
            send_cmd(random_cmd(phase_of_block[i / 100]), random_value(), 1'b0, UNTYPED);
        end
        cmd_valid <= 1'b0;
        quiet     <= 1'b0;

        while (pending_status.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d results over %0d commands; queue full %0d times.",
                 checked_results, accepted_cmds, full_count);
        $display("Dropped inserts %0d, deletes on empty %0d, input stall cycles %0d.",
                 drop_count, empty_delete_count, stall_cycles);
        if (error_count == 0)
        begin
            $display("double_ended_priority_queue verification clean");
        end
        else
        begin
            $display("double_ended_priority_queue verification failed");
        end
        $finish;
    end

endmodule
